@@ rtl/lbdp_pkg.sv @@
`default_nettype none
package lbdp_pkg;

  // Offset added to the two operand fields by the L-Mul rule.
  localparam logic [16:0] LMUL_OFFSET  = 17'h4080;
  // Product field used when the exponent sum saturates.
  localparam logic [14:0] FIELD_SAT    = 15'h7FFF;
  // Implicit leading one of a bfloat16 mantissa.
  localparam logic [7:0]  MANT_HIDDEN  = 8'h80;
  // Exponents whose conversion into Q15.16 is a left shift of 0..30.
  localparam logic [7:0]  EXP_LEFT_LO  = 8'd118;
  localparam logic [7:0]  EXP_LEFT_HI  = 8'd148;
  // Exponents whose conversion is a right shift of 1..30.
  localparam logic [7:0]  EXP_RIGHT_LO = 8'd88;
  // Exponent of a renormalized sum is the leading-one position plus this.
  localparam logic [7:0]  EXP_REBIAS   = 8'd111;

  // Carry bits of the L-Mul field sum.
  typedef enum logic [1:0] {
    CARRY_UNDER = 2'd0,
    CARRY_NORM  = 2'd1,
    CARRY_OVER  = 2'd2,
    CARRY_BOTH  = 2'd3
  } carry_e;

  // Sum that is on its way back to bfloat16, split into sign and magnitude.
  typedef struct packed {
    logic        zero;
    logic        sign;
    logic [4:0]  pos;
    logic [31:0] mag;
  } norm_t;

endpackage
`default_nettype wire

@@ rtl/lbdp_term.sv @@
`default_nettype none
module lbdp_term (
  input  logic [15:0] act_i,
  input  logic [15:0] weight_i,
  output logic [31:0] term_o
);
  import lbdp_pkg::*;

  logic [16:0] fsum;
  logic [14:0] field;
  logic        psign;
  logic [7:0]  pexp;
  logic [7:0]  mant;
  logic [4:0]  lsh;
  logic [4:0]  rsh;
  logic [37:0] lval;
  logic [31:0] mag;
  carry_e      carry;

  // Approximate product: exponent and mantissa fields are simply added.
  always_comb begin
    fsum  = {2'b00, act_i[14:0]} + {2'b00, weight_i[14:0]} + LMUL_OFFSET;
    carry = carry_e'(fsum[16:15]);
    unique case (carry)
      CARRY_UNDER: field = '0;
      CARRY_NORM:  field = fsum[14:0];
      CARRY_OVER:  field = FIELD_SAT;
      CARRY_BOTH:  field = FIELD_SAT;
      default:     field = FIELD_SAT;
    endcase
    if ((act_i[14:7] == 8'd0) || (weight_i[14:7] == 8'd0)) begin
      field = '0;
    end
    psign = (field != '0) && (act_i[15] ^ weight_i[15]);
  end

  // Conversion of the product to Q15.16; out-of-range exponents give zero.
  always_comb begin
    pexp = field[14:7];
    mant = MANT_HIDDEN | {1'b0, field[6:0]};
    lsh  = 5'(pexp - EXP_LEFT_LO);
    rsh  = 5'(EXP_LEFT_LO - pexp);
    lval = {30'd0, mant} << lsh;
    mag  = '0;
    if (field == '0) begin
      mag = '0;
    end else if ((pexp >= EXP_LEFT_LO) && (pexp <= EXP_LEFT_HI)) begin
      mag = lval[31:0];
    end else if ((pexp >= EXP_RIGHT_LO) && (pexp < EXP_LEFT_LO)) begin
      mag = {24'd0, mant >> rsh};
    end
    term_o = psign ? (32'd0 - mag) : mag;
  end

endmodule
`default_nettype wire

@@ rtl/lbdp_lead.sv @@
`default_nettype none
module lbdp_lead (
  input  logic [31:0]          sum_i,
  output lbdp_pkg::norm_t      norm_o
);
  import lbdp_pkg::*;

  logic [31:0] mag;
  logic [4:0]  pos;

  // Magnitude and leading-one position of the finished sum.
  always_comb begin
    mag = sum_i[31] ? (32'd0 - sum_i) : sum_i;
    pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) begin
        pos = 5'(i);
      end
    end
    norm_o.zero = (sum_i == '0);
    norm_o.sign = sum_i[31];
    norm_o.pos  = pos;
    norm_o.mag  = mag;
  end

endmodule
`default_nettype wire

@@ rtl/lbdp_pack.sv @@
`default_nettype none
module lbdp_pack (
  input  lbdp_pkg::norm_t norm_i,
  output logic [15:0]     bf_o
);
  import lbdp_pkg::*;

  logic [31:0] shifted;
  logic [4:0]  lsh;
  logic [7:0]  expo;

  // Left-align the leading one at bit 31; the next seven bits are the
  // truncated mantissa.
  always_comb begin
    lsh     = 5'd31 - norm_i.pos;
    shifted = norm_i.mag << lsh;
    expo    = {3'd0, norm_i.pos} + EXP_REBIAS;
    if (norm_i.zero) begin
      bf_o = '0;
    end else begin
      bf_o = {norm_i.sign, expo, shifted[30:24]};
    end
  end

endmodule
`default_nettype wire

@@ rtl/lmul_bf16_dot_product.sv @@
// Channel   | Dir | tdata (low bit first)                    | tlast
// s_axis    | in  | [15:0] act_value, [31:16] weight_value   | last_term
// m_axis    | out | [15:0] result_value                      | none
//
// One item is accepted per cycle while tready is high. Each item runs through
// an input register and a term register that holds its product in Q15.16. The
// accumulator add is the only feedback path and fixes the rate at one item per
// clock unless a last term waits on a stalled result. A last item then passes a
// sum register and two more stages for leading-one search and packing. Reset
// (rst_ni low) clears all valid flags and the accumulator. A stalled result
// holds only the occupied stages behind it; empty stages keep absorbing items.
`default_nettype none
module lmul_bf16_dot_product (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [15:0] act_value, [31:16] weight_value
  input  logic        s_axis_tlast_i,   // last_term
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [15:0] result_value
);
  import lbdp_pkg::*;

  // Stage 1: operand register.
  logic        v1_q, v1_d;
  logic [15:0] act_q, wgt_q;
  logic        last1_q;
  // Stage 2: Q15.16 term register.
  logic        v2_q, v2_d;
  logic [31:0] term_q;
  logic        last2_q;
  // Running sum.
  logic [31:0] acc_q, acc_d;
  // Stage 3: finished sum of a dot product.
  logic        v3_q, v3_d;
  logic [31:0] fin_q;
  // Stage 4: sign, magnitude and leading-one position.
  logic        v4_q, v4_d;
  norm_t       norm_q;
  // Result register.
  logic        ov_q, ov_d;
  logic [15:0] out_q;

  logic        rdy1, rdy2, rdy3, rdy4, rdy5;
  logic        take2;
  logic [31:0] term;
  logic [31:0] sum;
  norm_t       norm;
  logic [15:0] bf;

  lbdp_term u_term (
    .act_i    (act_q),
    .weight_i (wgt_q),
    .term_o   (term)
  );

  lbdp_lead u_lead (
    .sum_i  (fin_q),
    .norm_o (norm)
  );

  lbdp_pack u_pack (
    .norm_i (norm_q),
    .bf_o   (bf)
  );

  // Each stage moves when the stage ahead is empty or moving. A term that is
  // not the last one leaves the pipeline at the accumulator, so only last
  // terms wait on the result side.
  always_comb begin
    rdy5  = !ov_q || m_axis_tready_i;
    rdy4  = !v4_q || rdy5;
    rdy3  = !v3_q || rdy4;
    take2 = v2_q && (!last2_q || rdy3);
    rdy2  = !v2_q || take2;
    rdy1  = !v1_q || rdy2;
    v1_d  = rdy1 ? s_axis_tvalid_i : v1_q;
    v2_d  = rdy2 ? v1_q : v2_q;
    v3_d  = rdy3 ? (take2 && last2_q) : v3_q;
    v4_d  = rdy4 ? v3_q : v4_q;
    ov_d  = rdy5 ? v4_q : ov_q;
  end

  // The last term is added before the sum is handed on, then the sum clears.
  always_comb begin
    sum   = acc_q + term_q;
    acc_d = acc_q;
    if (take2) begin
      acc_d = last2_q ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ov_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q  <= v1_d;
      v2_q  <= v2_d;
      v3_q  <= v3_d;
      v4_q  <= v4_d;
      ov_q  <= ov_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      act_q   <= s_axis_tdata_i[15:0];
      wgt_q   <= s_axis_tdata_i[31:16];
      last1_q <= s_axis_tlast_i;
    end
    if (rdy2) begin
      term_q  <= term;
      last2_q <= last1_q;
    end
    if (rdy3) begin
      fin_q <= sum;
    end
    if (rdy4) begin
      norm_q <= norm;
    end
    if (rdy5) begin
      out_q <= bf;
    end
  end

  assign s_axis_tready_o = rdy1;
  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = out_q;

endmodule
`default_nettype wire
